// ----- hw/rtl/rtcb_pkg.sv -----
// ----------------------------------------------------------------------------
// rtcb_pkg
// Shared types, constants and helper functions for the BCD real time clock.
// ----------------------------------------------------------------------------
package rtcb_pkg;

  // clock rates (ticks per second must be a power of two from 1024 up)
  localparam int TICKS_PER_SECOND = 32768;
  localparam int PULSE_TICKS      = 256;
  localparam int SIXTYFOURTH_STEP = (TICKS_PER_SECOND >= 64) ? TICKS_PER_SECOND / 64 : 1;

  localparam int SUB_W   = 15;
  localparam int PULSE_W = 9;

  localparam logic [SUB_W-1:0]   SUB_TOP   = SUB_W'(TICKS_PER_SECOND - 1);
  localparam logic [SUB_W-1:0]   STEP_MASK = SUB_W'(SIXTYFOURTH_STEP - 1);
  localparam logic [PULSE_W-1:0] PULSE_LOAD = PULSE_W'(PULSE_TICKS);

  // item operations
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_LOAD  = 2'd3
  } rtcb_op_t;

  // interrupt periods
  localparam logic [1:0] PER_64TH   = 2'd0;
  localparam logic [1:0] PER_SECOND = 2'd1;
  localparam logic [1:0] PER_MINUTE = 2'd2;
  localparam logic [1:0] PER_HOUR   = 2'd3;

  // register offsets
  localparam logic [3:0] ADDR_SEC_ONES  = 4'd0;
  localparam logic [3:0] ADDR_SEC_TENS  = 4'd1;
  localparam logic [3:0] ADDR_MIN_ONES  = 4'd2;
  localparam logic [3:0] ADDR_MIN_TENS  = 4'd3;
  localparam logic [3:0] ADDR_HR_ONES   = 4'd4;
  localparam logic [3:0] ADDR_HR_TENS   = 4'd5;
  localparam logic [3:0] ADDR_DAY_ONES  = 4'd6;
  localparam logic [3:0] ADDR_DAY_TENS  = 4'd7;
  localparam logic [3:0] ADDR_MON_ONES  = 4'd8;
  localparam logic [3:0] ADDR_MON_TENS  = 4'd9;
  localparam logic [3:0] ADDR_YR_ONES   = 4'd10;
  localparam logic [3:0] ADDR_YR_TENS   = 4'd11;
  localparam logic [3:0] ADDR_WEEKDAY   = 4'd12;
  localparam logic [3:0] ADDR_CTL_D     = 4'd13;
  localparam logic [3:0] ADDR_CTL_E     = 4'd14;
  localparam logic [3:0] ADDR_CTL_F     = 4'd15;

  // calendar and control registers
  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hr;
    logic [4:0] day;
    logic [3:0] mon;
    logic [6:0] yr;
    logic [2:0] wd;
    logic [3:0] ctl_d;
    logic [3:0] ctl_e;
    logic [3:0] ctl_f;
  } rtcb_regs_t;

  // binary to two bcd digits {tens, ones}, tens taken mod 10
  function automatic logic [7:0] bcd2(input logic [6:0] v);
    logic [11:0] acc;
    acc = '0;
    for (int i = 6; i >= 0; i--) begin
      if (acc[3:0] >= 4'd5) acc[3:0] = acc[3:0] + 4'd3;
      if (acc[7:4] >= 4'd5) acc[7:4] = acc[7:4] + 4'd3;
      acc = {acc[10:0], v[i]};
    end
    return acc[7:0];
  endfunction

  // days per month, out of range months count as 31
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd2:                   len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ----- hw/rtl/bcd_real_time_clock_with_periodic_irq.sv -----
// ----------------------------------------------------------------------------
// bcd_real_time_clock_with_periodic_irq
// Nibble-wide BCD real time clock with calendar and periodic interrupt.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------
//   in_     | input     | in_valid / in_ready  | operation, address, data, time
//   out_    | output    | out_valid / out_ready| read_data, irq_line
//
// One item per cycle while the result register is not stalled. An item is
// captured in the input register; when it advances, it updates the clock
// state and loads the result register. The input register refills in
// the same cycle it drains; a stalled result holds both stages.
// Reset (rst_n low, synchronous) returns to 00:00:00, day 1, month 1, year 0.
// ----------------------------------------------------------------------------
module bcd_real_time_clock_with_periodic_irq (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_operation,
  input  logic [3:0] in_address,
  input  logic [3:0] in_write_data,
  input  logic [6:0] in_load_year,
  input  logic [3:0] in_load_month,
  input  logic [4:0] in_load_day,
  input  logic [2:0] in_load_weekday,
  input  logic [4:0] in_load_hour,
  input  logic [5:0] in_load_minute,
  input  logic [5:0] in_load_second,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_read_data,
  output logic       out_irq_line
);
  import rtcb_pkg::*;

  // input stage
  logic       s1_valid_r;
  rtcb_op_t   s1_op_r;
  logic [3:0] s1_addr_r;
  logic [3:0] s1_data_r;
  logic [6:0] s1_yr_r;
  logic [3:0] s1_mon_r;
  logic [4:0] s1_day_r;
  logic [2:0] s1_wd_r;
  logic [4:0] s1_hr_r;
  logic [5:0] s1_min_r;
  logic [5:0] s1_sec_r;

  // clock state
  rtcb_regs_t         regs_r, regs_nxt;
  logic [SUB_W-1:0]   sub_r, sub_nxt;
  logic               irq_en_r, irq_en_nxt;
  logic [1:0]         irq_per_r, irq_per_nxt;
  logic [PULSE_W-1:0] pulse_r, pulse_nxt;
  logic               irq_r, irq_nxt;

  // result stage
  logic       out_valid_r;
  logic [3:0] out_data_r;
  logic       out_irq_r;

  logic       advance;
  logic       accept;
  logic [3:0] rd_mux;
  logic [4:0] mlen;
  logic       b0, b1, b2, b3, fire;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign accept   = in_valid && in_ready;

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_irq_line  = out_irq_r;

  rtcb_read u_read (
    .address   (s1_addr_r),
    .regs      (regs_r),
    .read_data (rd_mux)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (accept) begin
      s1_op_r   <= rtcb_op_t'(in_operation);
      s1_addr_r <= in_address;
      s1_data_r <= in_write_data;
      s1_yr_r   <= in_load_year;
      s1_mon_r  <= in_load_month;
      s1_day_r  <= in_load_day;
      s1_wd_r   <= in_load_weekday;
      s1_hr_r   <= in_load_hour;
      s1_min_r  <= in_load_minute;
      s1_sec_r  <= in_load_second;
    end
  end

  // month length with leap february
  always_comb begin
    mlen = month_len(regs_r.mon);
    if (regs_r.mon == 4'd2 && regs_r.yr[1:0] == 2'b00) mlen = 5'd29;
  end

  // state update for the item in the input register
  always_comb begin
    regs_nxt    = regs_r;
    sub_nxt     = sub_r;
    irq_en_nxt  = irq_en_r;
    irq_per_nxt = irq_per_r;
    pulse_nxt   = pulse_r;
    irq_nxt     = irq_r;
    b0 = 1'b0;
    b1 = 1'b0;
    b2 = 1'b0;
    b3 = 1'b0;
    fire = 1'b0;
    case (s1_op_r)
      OP_TICK: begin
        // pulse countdown runs first
        if (pulse_r != '0) begin
          pulse_nxt = pulse_r - PULSE_W'(1);
          if (pulse_nxt == '0) begin
            regs_nxt.ctl_d[2] = 1'b0;
            irq_nxt           = 1'b0;
          end
        end
        // subsecond and time carries
        sub_nxt = (sub_r >= SUB_TOP) ? '0 : sub_r + SUB_W'(1);
        b0 = (sub_nxt & STEP_MASK) == '0;
        b1 = (sub_nxt == '0);
        if (b1) begin
          if (regs_r.sec >= 6'd59) begin
            regs_nxt.sec = '0;
            b2 = 1'b1;
          end else begin
            regs_nxt.sec = regs_r.sec + 6'd1;
          end
        end
        if (b2) begin
          if (regs_r.min >= 6'd59) begin
            regs_nxt.min = '0;
            b3 = 1'b1;
          end else begin
            regs_nxt.min = regs_r.min + 6'd1;
          end
        end
        if (b3) begin
          if (regs_r.hr >= 5'd23) begin
            regs_nxt.hr = '0;
            // next day
            regs_nxt.wd = (regs_r.wd >= 3'd7) ? 3'd1 : regs_r.wd + 3'd1;
            if (regs_r.day >= mlen) begin
              regs_nxt.day = 5'd1;
              if (regs_r.mon >= 4'd12) begin
                regs_nxt.mon = 4'd1;
                regs_nxt.yr  = (regs_r.yr >= 7'd99) ? 7'd0 : regs_r.yr + 7'd1;
              end else begin
                regs_nxt.mon = regs_r.mon + 4'd1;
              end
            end else begin
              regs_nxt.day = regs_r.day + 5'd1;
            end
          end else begin
            regs_nxt.hr = regs_r.hr + 5'd1;
          end
        end
        // periodic interrupt
        fire = irq_en_r && ((irq_per_r == PER_64TH   && b0) ||
                            (irq_per_r == PER_SECOND && b1) ||
                            (irq_per_r == PER_MINUTE && b2) ||
                            (irq_per_r == PER_HOUR   && b3));
        if (fire) begin
          regs_nxt.ctl_d[2] = 1'b1;
          irq_nxt           = 1'b1;
          if (!regs_r.ctl_e[1]) pulse_nxt = PULSE_LOAD;
        end
      end
      OP_WRITE: begin
        case (s1_addr_r)
          ADDR_CTL_D: begin
            // acknowledge on a write with the flag bit clear
            if (!s1_data_r[2] && regs_r.ctl_d[2]) begin
              irq_nxt   = 1'b0;
              pulse_nxt = '0;
              regs_nxt.ctl_d = {s1_data_r[3], 1'b0, regs_r.ctl_d[1], s1_data_r[0]};
            end else begin
              regs_nxt.ctl_d = {s1_data_r[3], regs_r.ctl_d[2:1], s1_data_r[0]};
            end
          end
          ADDR_CTL_E: begin
            regs_nxt.ctl_e = s1_data_r;
            if (!s1_data_r[0]) begin
              irq_en_nxt  = 1'b1;
              irq_per_nxt = s1_data_r[3:2];
            end else begin
              irq_en_nxt        = 1'b0;
              regs_nxt.ctl_d[2] = 1'b0;
              irq_nxt           = 1'b0;
            end
          end
          ADDR_CTL_F: begin
            // 24 hour flag only latches on release of reset bit
            if (!s1_data_r[0] && regs_r.ctl_f[0]) begin
              regs_nxt.ctl_f = s1_data_r;
            end else begin
              regs_nxt.ctl_f = {s1_data_r[3], regs_r.ctl_f[2], s1_data_r[1:0]};
            end
          end
          default: ;
        endcase
      end
      OP_LOAD: begin
        regs_nxt.yr  = s1_yr_r;
        regs_nxt.mon = s1_mon_r;
        regs_nxt.day = s1_day_r;
        regs_nxt.wd  = s1_wd_r;
        regs_nxt.hr  = s1_hr_r;
        regs_nxt.min = s1_min_r;
        regs_nxt.sec = s1_sec_r;
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '{sec: 6'd0, min: 6'd0, hr: 5'd0, day: 5'd1, mon: 4'd1, yr: 7'd0,
                  wd: 3'd1, ctl_d: 4'd0, ctl_e: 4'd6, ctl_f: 4'd4};
      sub_r     <= '0;
      irq_en_r  <= 1'b0;
      irq_per_r <= PER_64TH;
      pulse_r   <= '0;
      irq_r     <= 1'b0;
    end else if (advance) begin
      regs_r    <= regs_nxt;
      sub_r     <= sub_nxt;
      irq_en_r  <= irq_en_nxt;
      irq_per_r <= irq_per_nxt;
      pulse_r   <= pulse_nxt;
      irq_r     <= irq_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (advance) begin
      out_data_r <= (s1_op_r == OP_READ) ? rd_mux : 4'd0;
      out_irq_r  <= irq_nxt;
    end
  end

  // irq line and the flag bit in control d move together
  a_irq_flag: assert property (@(posedge clk) disable iff (!rst_n)
    irq_r == regs_r.ctl_d[2])
    else $error("irq line and control d flag disagree");

  // pulse countdown never exceeds its load value
  a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
    pulse_r <= PULSE_LOAD)
    else $error("pulse countdown out of range");

  // an empty result stage never blocks the input
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty result stage");

  // reads leave the clock state alone
  a_read_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_op_r == OP_READ) |=> ($stable(regs_r) && $stable(sub_r) && $stable(irq_r)))
    else $error("read item changed clock state");

  // reported irq level matches the state after the item
  a_irq_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_irq_r == irq_r))
    else $error("result irq level differs from state");

endmodule

// ----- hw/rtl/rtcb_read.sv -----
// ----------------------------------------------------------------------------
// rtcb_read
// Bus read mux: BCD digits of the calendar, 12/24 hour view and controls.
// ----------------------------------------------------------------------------
module rtcb_read (
  input  logic [3:0]          address,
  input  rtcb_pkg::rtcb_regs_t regs,
  output logic [3:0]          read_data
);
  import rtcb_pkg::*;

  logic [4:0] hr_12;
  logic [4:0] hr_disp;
  logic       pm;
  logic [7:0] sec_bcd, min_bcd, hr_bcd, day_bcd, mon_bcd, yr_bcd;
  logic [3:0] wd_ext;

  // 12 hour conversion, bypassed in 24 hour mode
  always_comb begin
    if (regs.hr >= 5'd24) begin
      hr_12 = regs.hr - 5'd24;
    end else if (regs.hr >= 5'd12) begin
      hr_12 = regs.hr - 5'd12;
    end else begin
      hr_12 = regs.hr;
    end
    if (hr_12 == 5'd0) hr_12 = 5'd12;
    if (regs.ctl_f[2]) begin
      hr_disp = regs.hr;
      pm      = 1'b0;
    end else begin
      hr_disp = hr_12;
      pm      = (regs.hr >= 5'd12);
    end
  end

  // digit split
  assign sec_bcd = bcd2({1'b0, regs.sec});
  assign min_bcd = bcd2({1'b0, regs.min});
  assign hr_bcd  = bcd2({2'b0, hr_disp});
  assign day_bcd = bcd2({2'b0, regs.day});
  assign mon_bcd = bcd2({3'b0, regs.mon});
  assign yr_bcd  = bcd2(regs.yr);
  assign wd_ext  = {1'b0, regs.wd} - 4'd1;

  // offset select
  always_comb begin
    case (address)
      ADDR_SEC_ONES: read_data = sec_bcd[3:0];
      ADDR_SEC_TENS: read_data = sec_bcd[7:4];
      ADDR_MIN_ONES: read_data = min_bcd[3:0];
      ADDR_MIN_TENS: read_data = min_bcd[7:4];
      ADDR_HR_ONES:  read_data = hr_bcd[3:0];
      ADDR_HR_TENS:  read_data = hr_bcd[7:4] | {1'b0, pm, 2'b00};
      ADDR_DAY_ONES: read_data = day_bcd[3:0];
      ADDR_DAY_TENS: read_data = day_bcd[7:4];
      ADDR_MON_ONES: read_data = mon_bcd[3:0];
      ADDR_MON_TENS: read_data = mon_bcd[7:4];
      ADDR_YR_ONES:  read_data = yr_bcd[3:0];
      ADDR_YR_TENS:  read_data = yr_bcd[7:4];
      ADDR_WEEKDAY:  read_data = wd_ext;
      ADDR_CTL_D:    read_data = regs.ctl_d;
      ADDR_CTL_E:    read_data = regs.ctl_e;
      ADDR_CTL_F:    read_data = regs.ctl_f;
      default:       read_data = 4'd0;
    endcase
  end

endmodule
